[rtl/smd_pkg.sv]
// ---------------------------------------------------------------------------
// smd_pkg: shared types and constants for the segmentation mask decider
// Word formats, register map, decision modes and store sizes.
// ---------------------------------------------------------------------------
package smd_pkg;

	// store sizes
	localparam int MAX_PIXELS  = 65536;
	localparam int MAX_CLASSES = 32;
	localparam int PIX_AW      = $clog2(MAX_PIXELS);

	// decision queue between front and back
	localparam int DQ_DEPTH = 4;

	// mask byte construction
	localparam logic [7:0] BG_CODE    = 8'hE0;
	localparam int         HIST_SHIFT = 3;

	// register map
	localparam int REG_COUNT = 4;
	localparam int PADDR_W   = $clog2(4 * REG_COUNT);
	localparam logic [1:0] REG_MODE         = 2'd0;
	localparam logic [1:0] REG_CLASS_COUNT  = 2'd1;
	localparam logic [1:0] REG_PERSON_CLASS = 2'd2;
	localparam logic [1:0] REG_THRESHOLD    = 2'd3;

	// decision modes (code 3 acts as threshold)
	localparam logic [1:0] MODE_ARGMAX = 2'd0;
	localparam logic [1:0] MODE_THRESH = 2'd1;
	localparam logic [1:0] MODE_LOGIT  = 2'd2;

	// register reset values
	localparam logic [1:0]        RST_MODE         = MODE_THRESH;
	localparam logic [5:0]        RST_CLASS_COUNT  = 6'd21;
	localparam logic [4:0]        RST_PERSON_CLASS = 5'd15;
	localparam logic signed [15:0] RST_THRESHOLD   = 16'sd166;

	typedef struct packed {
		logic [15:0]        pixel_index;
		logic signed [15:0] score;
	} item_t;

	typedef struct packed {
		logic [15:0] out_pixel;
		logic [7:0]  mask_byte;
		logic        foreground;
	} result_t;

	// one finished pixel decision
	typedef struct packed {
		logic [15:0] pixel;
		logic        fg;
	} dec_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [5:0]         class_count;
		logic [4:0]         person_class;
		logic signed [15:0] threshold;
	} cfg_t;

endpackage

[rtl/smd_front.sv]
// ---------------------------------------------------------------------------
// smd_front: score classifier
// Runs the arg-max, threshold or two-logit decision on each accepted score
// word and emits one decision word when a pixel is complete.
// ---------------------------------------------------------------------------
module smd_front
	import smd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  item_t item,
	input  cfg_t  cfg,
	input  logic  restart,
	output logic  dec_valid,
	output dec_t  dec_word
);

	logic signed [15:0] best_score_q;
	logic [4:0]         best_class_q;
	logic [4:0]         score_cnt_q;

	logic [5:0]         n_eff;
	logic [4:0]         pos;
	logic [5:0]         pos_next;
	logic               take;
	logic [4:0]         class_new;
	logic               emit;
	logic               fg;
	logic signed [15:0] best_score_d;
	logic [4:0]         best_class_d;
	logic [4:0]         score_cnt_d;

	// effective class count, clamped to 1..MAX_CLASSES
	always_comb begin
		if (cfg.class_count == 6'd0) begin
			n_eff = 6'd1;
		end else if (cfg.class_count > 6'(MAX_CLASSES)) begin
			n_eff = 6'(MAX_CLASSES);
		end else begin
			n_eff = cfg.class_count;
		end
	end

	// position within the pixel and running max update
	assign pos       = ({1'b0, score_cnt_q} >= n_eff) ? 5'd0 : score_cnt_q;
	assign pos_next  = {1'b0, pos} + 6'd1;
	assign take      = (pos == 5'd0) || (item.score > best_score_q);
	assign class_new = take ? pos : best_class_q;

	// per-mode decision
	always_comb begin
		best_score_d = best_score_q;
		best_class_d = best_class_q;
		score_cnt_d  = score_cnt_q;
		emit         = 1'b0;
		fg           = 1'b0;
		unique case (cfg.mode)
			MODE_ARGMAX: begin
				if (take) begin
					best_score_d = item.score;
					best_class_d = pos;
				end
				if (pos_next >= n_eff) begin
					emit        = 1'b1;
					fg          = (class_new == cfg.person_class);
					score_cnt_d = 5'd0;
				end else begin
					score_cnt_d = pos_next[4:0];
				end
			end
			MODE_LOGIT: begin
				if (score_cnt_q == 5'd0) begin
					best_score_d = item.score;
					score_cnt_d  = 5'd1;
				end else begin
					emit        = 1'b1;
					fg          = (best_score_q < item.score);
					score_cnt_d = 5'd0;
				end
			end
			default: begin
				emit = 1'b1;
				fg   = (item.score > cfg.threshold);
			end
		endcase
	end

	// classifier state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_score_q <= '0;
			best_class_q <= '0;
			score_cnt_q  <= '0;
		end else if (restart) begin
			score_cnt_q <= '0;
		end else if (accept) begin
			best_score_q <= best_score_d;
			best_class_q <= best_class_d;
			score_cnt_q  <= score_cnt_d;
		end
	end

	assign dec_valid      = accept && emit;
	assign dec_word.pixel = item.pixel_index;
	assign dec_word.fg    = fg;

endmodule

[rtl/smd_dq.sv]
// ---------------------------------------------------------------------------
// smd_dq: decision queue
// Short FIFO of decision words between the classifier and the mask updater.
// ---------------------------------------------------------------------------
module smd_dq
	import smd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  dec_t wr_word,
	input  logic rd,
	output dec_t rd_word,
	output logic valid,
	output logic full
);

	localparam int PW = $clog2(DQ_DEPTH);
	localparam int CW = $clog2(DQ_DEPTH + 1);

	dec_t          fifo_q [DQ_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign valid   = (cnt_q != '0);
	assign full    = (cnt_q == CW'(DQ_DEPTH));
	assign rd_word = fifo_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr) begin
			fifo_q[wr_ptr_q] <= wr_word;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// never written when full unless also read in the same cycle, never read when empty
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> (!full || rd))
		else $error("decision queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> valid)
		else $error("decision queue read while empty");

endmodule

[rtl/smd_back.sv]
// ---------------------------------------------------------------------------
// smd_back: mask history updater
// Clears the history store after reset, then does one read-modify-write
// per decision word and queues the result words.
// ---------------------------------------------------------------------------
module smd_back
	import smd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    dq_valid,
	input  dec_t    dq_word,
	output logic    dq_pop,
	input  logic    pop,
	output logic    empty,
	output result_t result,
	output logic    busy
);

	localparam int OUT_DEPTH = 2;
	localparam int OPW       = $clog2(OUT_DEPTH);
	localparam int OCW       = $clog2(OUT_DEPTH + 1);

	logic [7:0]        mem [MAX_PIXELS];
	logic              clr_q;
	logic [PIX_AW-1:0] clr_addr_q;

	logic              valid_s1;
	logic [15:0]       pix_s1;
	logic              fg_s1;
	logic [7:0]        rdata_q;
	logic              fwd_q;
	logic [7:0]        fwd_data_q;

	result_t           oq_q [OUT_DEPTH];
	logic [OPW-1:0]    oq_wr_q;
	logic [OPW-1:0]    oq_rd_q;
	logic [OCW-1:0]    oq_cnt_q;

	logic              adv_s1;
	logic              load_s1;
	logic              out_pop;
	logic [7:0]        old_byte;
	logic [7:0]        new_byte;
	logic              mem_we;
	logic [PIX_AW-1:0] mem_wa;
	logic [7:0]        mem_wd;
	logic [PIX_AW-1:0] rd_addr;

	// stage control
	assign out_pop = pop && !empty;
	assign adv_s1  = valid_s1 && (oq_cnt_q != OCW'(OUT_DEPTH));
	assign load_s1 = dq_valid && !clr_q && (!valid_s1 || adv_s1);
	assign dq_pop  = load_s1;
	assign busy    = clr_q;
	assign rd_addr = dq_word.pixel[PIX_AW-1:0];

	// new mask byte, forwarding the previous write to the same pixel
	assign old_byte = fwd_q ? fwd_data_q : rdata_q;
	assign new_byte = (fg_s1 ? 8'h00 : BG_CODE) | (old_byte >> HIST_SHIFT);

	// single write port: clearing pass, then updates
	assign mem_we = clr_q || adv_s1;
	assign mem_wa = clr_q ? clr_addr_q : pix_s1[PIX_AW-1:0];
	assign mem_wd = clr_q ? 8'h00 : new_byte;

	// history store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (load_s1) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// stage 1 payload and forward data
	always_ff @(posedge clk) begin
		if (load_s1) begin
			pix_s1     <= dq_word.pixel;
			fg_s1      <= dq_word.fg;
			fwd_data_q <= new_byte;
		end
	end

	// clearing pass and stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			valid_s1   <= 1'b0;
			fwd_q      <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + PIX_AW'(1);
				if (clr_addr_q == PIX_AW'(MAX_PIXELS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (load_s1) begin
				valid_s1 <= 1'b1;
				fwd_q    <= adv_s1 && (rd_addr == pix_s1[PIX_AW-1:0]);
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			oq_q[oq_wr_q] <= '{out_pixel: pix_s1, mask_byte: new_byte, foreground: fg_s1};
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (adv_s1) begin
				oq_wr_q <= oq_wr_q + OPW'(1);
			end
			if (out_pop) begin
				oq_rd_q <= oq_rd_q + OPW'(1);
			end
			if (adv_s1 && !out_pop) begin
				oq_cnt_q <= oq_cnt_q + OCW'(1);
			end else if (out_pop && !adv_s1) begin
				oq_cnt_q <= oq_cnt_q - OCW'(1);
			end
		end
	end

	assign empty  = (oq_cnt_q == '0);
	assign result = oq_q[oq_rd_q];

	// nothing moves through the update path during the clearing pass
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> (!valid_s1 && empty))
		else $error("update path active during clearing pass");

	// a same-pixel write issued at the load edge is always forwarded
	a_fwd_origin: assert property (@(posedge clk) disable iff (!arst_n)
		load_s1 && adv_s1 && (rd_addr == pix_s1[PIX_AW-1:0]) |=> fwd_q)
		else $error("missed forward of same-pixel write");

	// stage 1 never advances into a full result queue
	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oq_cnt_q == OCW'(OUT_DEPTH) |=> oq_cnt_q <= OCW'(OUT_DEPTH))
		else $error("result queue overflow");

endmodule

[rtl/segmentation_mask_decider_top.sv]
// ---------------------------------------------------------------------------
// segmentation_mask_decider_top: per-pixel foreground decision with history
// Score words in, mask update words out, APB register port.
// ---------------------------------------------------------------------------
// One score word is accepted per cycle while full is low, and each finished
// pixel gives one result word; the update path sustains one result per
// cycle while the result queue has room. The classifier decides in the cycle
// a word is accepted. The history store has one read port and one write
// port; the read is registered as a word loads into stage 1 and the write
// follows as stage 1 advances, with back-to-back updates of the same pixel
// forwarded. A result passes the decision queue, stage 1 and the result
// queue before it is ready. After reset the 65536-entry history store is
// cleared one entry per cycle; full stays high and registers can be written
// during the pass. Change registers only while the block is idle.
// ---------------------------------------------------------------------------
module segmentation_mask_decider_top
	import smd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// score words
	input  logic               push,
	output logic               full,
	input  item_t              item,
	// result words
	output logic               empty,
	input  logic               pop,
	output result_t            result,
	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       reg_wr;
	logic       restart;

	logic       accept;
	logic       dec_valid;
	dec_t       dec_word;
	logic       dq_valid;
	logic       dq_full;
	dec_t       dq_word;
	logic       dq_pop;
	logic       busy;

	// register port
	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite;
	assign restart = reg_wr && ((reg_idx == REG_MODE) || (reg_idx == REG_CLASS_COUNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode         <= RST_MODE;
			cfg_q.class_count  <= RST_CLASS_COUNT;
			cfg_q.person_class <= RST_PERSON_CLASS;
			cfg_q.threshold    <= RST_THRESHOLD;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_MODE:         cfg_q.mode         <= pwdata[1:0];
				REG_CLASS_COUNT:  cfg_q.class_count  <= pwdata[5:0];
				REG_PERSON_CLASS: cfg_q.person_class <= pwdata[4:0];
				REG_THRESHOLD:    cfg_q.threshold    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			REG_MODE:         prdata = {30'd0, cfg_q.mode};
			REG_CLASS_COUNT:  prdata = {26'd0, cfg_q.class_count};
			REG_PERSON_CLASS: prdata = {27'd0, cfg_q.person_class};
			REG_THRESHOLD:    prdata = {16'd0, cfg_q.threshold};
			default:          prdata = 32'd0;
		endcase
	end

	// input handshake
	assign full   = busy || dq_full;
	assign accept = push && !full;

	smd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.cfg       (cfg_q),
		.restart   (restart),
		.dec_valid (dec_valid),
		.dec_word  (dec_word)
	);

	smd_dq u_dq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (dec_valid),
		.wr_word (dec_word),
		.rd      (dq_pop),
		.rd_word (dq_word),
		.valid   (dq_valid),
		.full    (dq_full)
	);

	smd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.dq_valid (dq_valid),
		.dq_word  (dq_word),
		.dq_pop   (dq_pop),
		.pop      (pop),
		.empty    (empty),
		.result   (result),
		.busy     (busy)
	);

endmodule
